>>> rtl/ggpc_pkg.sv
// Shared widths, lane and step types, and the arctangent table of the go-to-goal controller.
package ggpc_pkg;

  // Pipeline depth: one cell per CORDIC iteration or square root digit
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 21;
  localparam int N_CELLS      = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

  // Field and datapath widths
  localparam int W_COORD = 20;
  localparam int W_MAG   = 19;
  localparam int W_DIFF  = 21;
  localparam int W_CX    = 32;
  localparam int W_Z     = 28;
  localparam int W_SQ    = 42;
  localparam int W_ROOT  = 21;
  localparam int W_SHIFT = 5;
  localparam int W_THRSQ = 2 * W_MAG;
  localparam int W_PROD  = W_MAG + W_ROOT;

  localparam logic [W_MAG-1:0]      FIELD_MAX = '1;
  localparam logic signed [W_Z-1:0] PI_Q24    = 28'sd52707179;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET_X   = 3'd0,
    REG_TARGET_Y   = 3'd1,
    REG_GAIN       = 3'd2,
    REG_MAX_SPEED  = 3'd3,
    REG_ARRIVE_THR = 3'd4,
    REG_TURN_THR   = 3'd5
  } cfg_reg_t;

  // Data that one cell hands to the next
  typedef struct packed {
    logic signed [W_CX-1:0]    x;
    logic signed [W_CX-1:0]    y;
    logic signed [W_Z-1:0]     z;
    logic [W_SQ-1:0]           n;
    logic [W_SQ-1:0]           res;
    logic signed [W_COORD-1:0] head;
    logic                      move;
  } lane_t;

  // Fixed per-cell controls
  typedef struct packed {
    logic                  cordic_en;
    logic                  sqrt_en;
    logic [W_SHIFT-1:0]    shift;
    logic signed [W_Z-1:0] atan;
    logic [W_SQ-1:0]       sbit;
  } step_t;

  // One velocity command, linear speed in the low bits
  typedef struct packed {
    logic [W_MAG-1:0] turn_rate;
    logic [W_MAG-1:0] linear_speed;
  } cmd_t;

  // atan(2^-i) in Q24 radians
  function automatic logic signed [W_Z-1:0] atan_q24(input int i);
    logic signed [W_Z-1:0] v;
    case (i)
      0:  v = 28'sd13176795;
      1:  v = 28'sd7778716;
      2:  v = 28'sd4110060;
      3:  v = 28'sd2086331;
      4:  v = 28'sd1047214;
      5:  v = 28'sd524117;
      6:  v = 28'sd262123;
      7:  v = 28'sd131069;
      8:  v = 28'sd65536;
      9:  v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Controls for cell i of the chain
  function automatic step_t step_of(input int i);
    step_t s;
    s.cordic_en = (i < CORDIC_STEPS);
    s.sqrt_en   = (i < SQRT_STEPS);
    s.shift     = W_SHIFT'(i);
    s.atan      = atan_q24(i);
    if (i < SQRT_STEPS) begin
      s.sbit = W_SQ'(1) << (2 * (SQRT_STEPS - 1 - i));
    end else begin
      s.sbit = '0;
    end
    return s;
  endfunction

endpackage

>>> rtl/go_to_goal_p_controller.sv
// Top level of the go-to-goal proportional controller: registers, cell chain and I/O.
//
// Accepts one pose per clock cycle and returns one velocity command per pose, in order.
// The pose runs through two entry stages, a chain of N_CELLS cells (21 with 16 CORDIC
// iterations; every cell does one square root digit, the first CORDIC_STEPS cells also one
// CORDIC iteration), one exit stage and a two-entry output buffer. The input stalls only
// while both buffer entries are occupied. Configuration writes take effect on the next pose
// and on poses already in flight, and should be made while no pose is in flight.
module go_to_goal_p_controller (
  input  logic        clk,
  input  logic        rst,
  // pose: pos_x[19:0], pos_y[39:20], heading[59:40], zero pad [63:60]
  input  logic [63:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command: linear_speed[18:0], turn_rate[37:19], zero pad [39:38]
  output logic [39:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import ggpc_pkg::*;

  logic signed [W_COORD-1:0] target_x;
  logic signed [W_COORD-1:0] target_y;
  logic [W_MAG-1:0]          gain;
  logic [W_MAG-1:0]          max_speed;
  logic [W_MAG-1:0]          arrive_threshold;
  logic [W_MAG-1:0]          turn_threshold;
  logic [W_THRSQ-1:0]        thr_sq;
  logic                      en;
  logic                      cv [N_CELLS+1];
  lane_t                     cl [N_CELLS+1];
  step_t                     steps [N_CELLS];
  cmd_t                      cmd;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x         <= 20'sd4096;
      target_y         <= 20'sd4096;
      gain             <= 19'd4096;
      max_speed        <= 19'd12288;
      arrive_threshold <= 19'd410;
      turn_threshold   <= 19'd819;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_X:   target_x         <= cfg_data;
        REG_TARGET_Y:   target_y         <= cfg_data;
        REG_GAIN:       gain             <= cfg_data[W_MAG-1:0];
        REG_MAX_SPEED:  max_speed        <= cfg_data[W_MAG-1:0];
        REG_ARRIVE_THR: arrive_threshold <= cfg_data[W_MAG-1:0];
        REG_TURN_THR:   turn_threshold   <= cfg_data[W_MAG-1:0];
        default:        target_x         <= target_x;
      endcase
    end
  end

  // Squared arrival radius
  always_ff @(posedge clk) begin
    thr_sq <= arrive_threshold * arrive_threshold;
  end

  assign s_tready = en;

  ggpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .pos_x     (s_tdata[19:0]),
    .pos_y     (s_tdata[39:20]),
    .heading   (s_tdata[59:40]),
    .target_x  (target_x),
    .target_y  (target_y),
    .thr_sq    (thr_sq),
    .out_valid (cv[0]),
    .out_lane  (cl[0])
  );

  // Chain of cells
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    assign steps[i] = step_of(i);

    ggpc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .step      (steps[i]),
      .in_valid  (cv[i]),
      .in_lane   (cl[i]),
      .out_valid (cv[i+1]),
      .out_lane  (cl[i+1])
    );
  end

  ggpc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (cv[N_CELLS]),
    .in_lane        (cl[N_CELLS]),
    .gain           (gain),
    .max_speed      (max_speed),
    .turn_threshold (turn_threshold),
    .room           (en),
    .m_valid        (m_tvalid),
    .m_ready        (m_tready),
    .m_cmd          (cmd)
  );

  assign m_tdata = {2'b00, cmd};

endmodule

>>> rtl/ggpc_cell.sv
// One chain cell: a CORDIC vectoring iteration and a square root digit step, each where its step enables it.
module ggpc_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ggpc_pkg::step_t step,
  input  logic            in_valid,
  input  ggpc_pkg::lane_t in_lane,
  output logic            out_valid,
  output ggpc_pkg::lane_t out_lane
);
  import ggpc_pkg::*;

  logic signed [W_CX-1:0] x;
  logic signed [W_CX-1:0] y;
  logic signed [W_CX-1:0] xs;
  logic signed [W_CX-1:0] ys;
  logic [W_SQ:0]          trial;
  lane_t                  lane_next;

  // Rotate toward the x axis and try the next root digit
  always_comb begin
    x         = in_lane.x;
    y         = in_lane.y;
    xs        = x >>> step.shift;
    ys        = y >>> step.shift;
    trial     = {1'b0, in_lane.res} + {1'b0, step.sbit};
    lane_next = in_lane;
    if (step.cordic_en) begin
      if (!y[W_CX-1]) begin
        lane_next.x = x + ys;
        lane_next.y = y - xs;
        lane_next.z = in_lane.z + step.atan;
      end else begin
        lane_next.x = x - ys;
        lane_next.y = y + xs;
        lane_next.z = in_lane.z - step.atan;
      end
    end
    if (step.sqrt_en) begin
      if ({1'b0, in_lane.n} >= trial) begin
        lane_next.n   = in_lane.n - trial[W_SQ-1:0];
        lane_next.res = (in_lane.res >> 1) + step.sbit;
      end else begin
        lane_next.res = in_lane.res >> 1;
      end
    end
  end

  // Hand the lane to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane <= lane_next;
    end
  end

endmodule

>>> rtl/ggpc_front.sv
// Entry stages: offsets to the goal, squared distance, quadrant fold and arrival test.
module ggpc_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic signed [ggpc_pkg::W_COORD-1:0]     pos_x,
  input  logic signed [ggpc_pkg::W_COORD-1:0]     pos_y,
  input  logic signed [ggpc_pkg::W_COORD-1:0]     heading,
  input  logic signed [ggpc_pkg::W_COORD-1:0]     target_x,
  input  logic signed [ggpc_pkg::W_COORD-1:0]     target_y,
  input  logic [ggpc_pkg::W_THRSQ-1:0]            thr_sq,
  output logic                                    out_valid,
  output ggpc_pkg::lane_t                         out_lane
);
  import ggpc_pkg::*;

  logic                      v1;
  logic signed [W_DIFF-1:0]  dx;
  logic signed [W_DIFF-1:0]  dy;
  logic signed [W_COORD-1:0] h1;
  logic signed [W_SQ-1:0]    sqx;
  logic signed [W_SQ-1:0]    sqy;
  logic signed [W_CX-1:0]    xe;
  logic signed [W_CX-1:0]    ye;
  lane_t                     lane0;
  lane_t                     lane2;

  // Offsets from the pose to the goal
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= {target_x[W_COORD-1], target_x} - {pos_x[W_COORD-1], pos_x};
      dy <= {target_y[W_COORD-1], target_y} - {pos_y[W_COORD-1], pos_y};
      h1 <= heading;
    end
  end

  // Square the offsets and fold the left half plane by pi
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign xe  = {{(W_CX-W_DIFF-8){dx[W_DIFF-1]}}, dx, 8'd0};
  assign ye  = {{(W_CX-W_DIFF-8){dy[W_DIFF-1]}}, dy, 8'd0};

  always_comb begin
    lane0      = '0;
    lane0.n    = W_SQ'(sqx) + W_SQ'(sqy);
    lane0.head = h1;
    if (dx[W_DIFF-1]) begin
      lane0.x = -xe;
      lane0.y = -ye;
      lane0.z = dy[W_DIFF-1] ? -PI_Q24 : PI_Q24;
    end else begin
      lane0.x = xe;
      lane0.y = ye;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane2 <= lane0;
    end
  end

  // Flag poses still outside the arrival circle
  always_comb begin
    out_lane      = lane2;
    out_lane.move = lane2.n > {{(W_SQ-W_THRSQ){1'b0}}, thr_sq};
  end

endmodule

>>> rtl/ggpc_back.sv
// Exit stages: bearing error, speed product, command select and two-entry output buffer.
module ggpc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  ggpc_pkg::lane_t              in_lane,
  input  logic [ggpc_pkg::W_MAG-1:0]   gain,
  input  logic [ggpc_pkg::W_MAG-1:0]   max_speed,
  input  logic [ggpc_pkg::W_MAG-1:0]   turn_threshold,
  output logic                         room,
  output logic                         m_valid,
  input  logic                         m_ready,
  output ggpc_pkg::cmd_t               m_cmd
);
  import ggpc_pkg::*;

  logic signed [W_Z:0]     zr;
  logic signed [16:0]      bear;
  logic signed [21:0]      err;
  logic signed [21:0]      aerr_full;
  logic                    pv;
  logic                    p_move;
  logic [W_ROOT-1:0]       p_aerr;
  logic [W_PROD-1:0]       p_prod;
  logic [W_PROD-13:0]      lin_raw;
  logic [W_MAG-1:0]        lin;
  logic [W_MAG-1:0]        turn;
  cmd_t                    cmd_new;
  cmd_t                    o0;
  cmd_t                    o1;
  logic [1:0]              count;
  logic                    push;
  logic                    pop;

  // Round the angle to Q12 and take the error against the heading
  assign zr        = {in_lane.z[W_Z-1], in_lane.z} + (W_Z+1)'(2048);
  assign bear      = zr[W_Z:12];
  assign err       = {{5{bear[16]}}, bear} - {{2{in_lane.head[W_COORD-1]}}, in_lane.head};
  assign aerr_full = err[21] ? -err : err;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (room) begin
      pv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room) begin
      p_move <= in_lane.move;
      p_aerr <= aerr_full[W_ROOT-1:0];
      p_prod <= gain * in_lane.res[W_ROOT-1:0];
    end
  end

  // Choose stop, turn in place or drive
  assign lin_raw = p_prod[W_PROD-1:12];
  assign lin     = (lin_raw > (W_PROD-12)'(max_speed)) ? max_speed : lin_raw[W_MAG-1:0];
  assign turn    = (p_aerr > W_ROOT'(FIELD_MAX)) ? FIELD_MAX : p_aerr[W_MAG-1:0];

  always_comb begin
    cmd_new = '0;
    if (p_move) begin
      if (p_aerr > W_ROOT'(turn_threshold)) begin
        cmd_new.turn_rate = turn;
      end else begin
        cmd_new.linear_speed = lin;
      end
    end
  end

  // Output buffer: hold up to two commands
  assign room    = (count != 2'd2);
  assign push    = room && pv;
  assign m_valid = (count != 2'd0);
  assign pop     = m_valid && m_ready;
  assign m_cmd   = o0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          o0 <= cmd_new;
        end else begin
          o1 <= cmd_new;
        end
      end
      2'b01:   o0 <= o1;
      2'b11:   o0 <= cmd_new;
      default: o0 <= o0;
    endcase
  end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the go-to-goal proportional controller stream block.
`timescale 1ns / 100ps

module testbench;
  import ggpc_pkg::*;

  localparam longint COORD_MAX     = 524287;
  localparam longint COORD_MIN     = -524288;
  localparam longint MAG_MAX       = 524287;
  localparam longint HALF_TURN_Q24 = 52707179;
  localparam longint ATAN_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  // Spare register indexes past the end of the map; writes there must be ignored
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // Pose fields from the highest bit down, matching s_tdata
  typedef struct packed {
    logic signed [W_COORD-1:0] heading;
    logic signed [W_COORD-1:0] pos_y;
    logic signed [W_COORD-1:0] pos_x;
  } pose_t;

  // Golden controller model plus the queue of commands still owed by the block
  class cmd_scoreboard;
    logic signed [W_COORD-1:0] tgt_x, tgt_y;
    logic [W_MAG-1:0] gain, max_speed, arrive_thr, turn_thr;
    cmd_t pending_cmds[$];
    int mismatch_count;
    int poses_seen;
    int n_stopped, n_turning, n_driving;

    function new();
      tgt_x = 4096;
      tgt_y = 4096;
      gain = 4096;
      max_speed = 12288;
      arrive_thr = 410;
      turn_thr = 819;
      mismatch_count = 0;
      poses_seen = 0;
      n_stopped = 0;
      n_turning = 0;
      n_driving = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [19:0] data);
      case (idx)
        REG_TARGET_X:   tgt_x = data;
        REG_TARGET_Y:   tgt_y = data;
        REG_GAIN:       gain = data[W_MAG-1:0];
        REG_MAX_SPEED:  max_speed = data[W_MAG-1:0];
        REG_ARRIVE_THR: arrive_thr = data[W_MAG-1:0];
        REG_TURN_THR:   turn_thr = data[W_MAG-1:0];
        default: ;
      endcase
    endfunction

    // Bitwise integer square root, floor
    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    // CORDIC vectoring atan2(dy, dx), Q12 radians
    function longint bearing_of(longint dx, longint dy);
      longint x, y, z, xs, ys;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      // fold the left half-plane over by a half turn
      if (x < 0) begin
        z = (y >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_Q24[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_Q24[i];
        end
      end
      return (z + 2048) >>> 12;
    endfunction

    function cmd_t predict_cmd(pose_t p);
      longint dx, dy, sq, err, aerr, lin, turn;
      cmd_t c;
      dx = longint'(tgt_x) - longint'(p.pos_x);
      dy = longint'(tgt_y) - longint'(p.pos_y);
      sq = dx * dx + dy * dy;
      lin = 0;
      turn = 0;
      if (sq > longint'(arrive_thr) * longint'(arrive_thr)) begin
        err = bearing_of(dx, dy) - longint'(p.heading);
        aerr = (err < 0) ? -err : err;
        if (aerr > longint'(turn_thr)) begin
          turn = (aerr > MAG_MAX) ? MAG_MAX : aerr;
        end else begin
          lin = (longint'(gain) * longint'(int_sqrt(sq))) >>> 12;
          if (lin > longint'(max_speed)) lin = longint'(max_speed);
          if (lin > MAG_MAX) lin = MAG_MAX;
        end
      end
      c.linear_speed = lin[W_MAG-1:0];
      c.turn_rate = turn[W_MAG-1:0];
      return c;
    endfunction

    function void note_pose(pose_t p);
      cmd_t c;
      c = predict_cmd(p);
      pending_cmds.push_back(c);
      poses_seen++;
      if (c.turn_rate != 0) n_turning++;
      else if (c.linear_speed != 0) n_driving++;
      else n_stopped++;
    endfunction

    function void check_cmd(logic [39:0] tdata);
      cmd_t got, want;
      got = tdata[2*W_MAG-1:0];
      if (pending_cmds.size() == 0) begin
        $error("command with no pose pending: linear_speed %0d turn_rate %0d",
               got.linear_speed, got.turn_rate);
        mismatch_count++;
        return;
      end
      want = pending_cmds.pop_front();
      if (got.linear_speed !== want.linear_speed) begin
        $error("linear_speed mismatch: expected %0d, actual %0d",
               want.linear_speed, got.linear_speed);
        mismatch_count++;
      end
      if (got.turn_rate !== want.turn_rate) begin
        $error("turn_rate mismatch: expected %0d, actual %0d",
               want.turn_rate, got.turn_rate);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  // pose: pos_x[19:0], pos_y[39:20], heading[59:40], zero pad [63:60]
  logic [63:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // command: linear_speed[18:0], turn_rate[37:19], zero pad [39:38]
  logic [39:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  cmd_scoreboard sb;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold_cycles = 0;

  go_to_goal_p_controller DUT (
    .clk,
    .rst,
    .s_tdata,
    .s_tvalid,
    .s_tready,
    .m_tdata,
    .m_tvalid,
    .m_tready,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  always #1 clk = ~clk;

  function automatic logic signed [W_COORD-1:0] clip20(longint v);
    if (v > COORD_MAX) return COORD_MAX[W_COORD-1:0];
    if (v < COORD_MIN) return COORD_MIN[W_COORD-1:0];
    return v[W_COORD-1:0];
  endfunction

  function automatic longint rand_span(int unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  // Mix of raw random poses, poses around the goal, and poses aimed near the bearing
  function automatic pose_t rand_pose();
    pose_t p;
    int unsigned kind, span;
    longint dx, dy;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      p.pos_x = W_COORD'($urandom);
      p.pos_y = W_COORD'($urandom);
      p.heading = W_COORD'($urandom);
    end else begin
      span = ($urandom_range(0, 2) == 0) ? 2048 : ($urandom_range(0, 1) ? 32768 : 400000);
      p.pos_x = clip20(longint'(sb.tgt_x) + rand_span(span));
      p.pos_y = clip20(longint'(sb.tgt_y) + rand_span(span));
      if (kind < 5) begin
        p.heading = W_COORD'($urandom);
      end else begin
        dx = longint'(sb.tgt_x) - longint'(p.pos_x);
        dy = longint'(sb.tgt_y) - longint'(p.pos_y);
        p.heading = clip20(sb.bearing_of(dx, dy) + rand_span(int'(sb.turn_thr) + 64));
      end
    end
    return p;
  endfunction

  // Offer one pose after a random gap and hold it until the transfer
  task automatic send_pose(pose_t p);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    repeat (gap) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = {4'b0, p};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_pose(p);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [19:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop offering poses and wait until every owed command has come out
  task automatic drain_cmds();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic apply_setting(int k);
    case (k)
      1: begin
        // extremes: far corner goal, top gain and clamp, zero stop distance
        write_cfg(REG_TARGET_X, 20'h80000);
        write_cfg(REG_TARGET_Y, 20'h7FFFF);
        write_cfg(REG_GAIN, 20'hFFFFF);
        write_cfg(REG_MAX_SPEED, 20'hFFFFF);
        write_cfg(REG_ARRIVE_THR, 20'h00000);
        write_cfg(REG_TURN_THR, 20'h7FFFF);
        write_cfg(REG_SPARE_A, 20'h00001);
        write_cfg(REG_SPARE_B, 20'($urandom));
      end
      2: begin
        // opposite extremes: zero gain and clamp, widest stop, any error turns
        write_cfg(REG_TARGET_X, 20'h00000);
        write_cfg(REG_TARGET_Y, 20'h00000);
        write_cfg(REG_GAIN, 20'h00000);
        write_cfg(REG_MAX_SPEED, 20'h00000);
        write_cfg(REG_ARRIVE_THR, 20'h7FFFF);
        write_cfg(REG_TURN_THR, 20'h00000);
      end
      default: begin
        write_cfg(REG_TARGET_X, 20'(rand_span(65536)));
        write_cfg(REG_TARGET_Y, 20'(rand_span(65536)));
        write_cfg(REG_GAIN, 20'($urandom_range(0, 16384)));
        write_cfg(REG_MAX_SPEED, 20'($urandom_range(0, 32768)));
        write_cfg(REG_ARRIVE_THR, 20'($urandom_range(0, 2048)));
        write_cfg(REG_TURN_THR, 20'($urandom_range(0, 8192)));
        write_cfg(REG_SPARE_B, 20'($urandom));
      end
    endcase
  endtask

  // Result side: random ready gaps, plus a long hold-off on request
  initial begin
    int gap;
    m_tready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        m_tready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_idle ? $urandom_range(0, 14) : 0;
      repeat (gap) begin
        m_tready = 1'b0;
        @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_cmd(m_tdata);
      @(negedge clk);
    end
  end

  // Main sequence
  initial begin
    pose_t p;
    int dir_tab [0:18][0:2];
    dir_tab = '{
      '{4096, 4096, 0},            // exactly at the goal
      '{4396, 4096, 0},            // inside the stop radius
      '{4506, 4096, 0},            // on the stop radius
      '{4507, 4096, 12868},        // just outside, facing the goal from behind
      '{0, 4096, 0},               // straight ahead, unclamped
      '{-524288, 4096, 0},         // far ahead, clamped to max speed
      '{0, 0, 3217},               // diagonal, facing the goal
      '{0, 0, 0},                  // diagonal, turn in place
      '{0, 0, -524288},            // error beyond the field, saturate
      '{0, 0, 524287},             // large error just under the field
      '{8192, 4096, 12868},        // goal behind on the axis, plus half turn
      '{8192, 4097, -12868},       // goal behind just below, minus half turn
      '{524287, -524288, 0},
      '{-524288, 524287, 524287},
      '{524287, 524287, -524288},
      '{-524288, -524288, -524288},
      '{4096, 0, 6434},            // goal straight up
      '{4096, 8192, -6434},        // goal straight down
      '{4096, 0, 0}                // goal straight up, turn in place
    };
    sb = new();
    s_tvalid = 1'b0;
    cfg_valid = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed poses under the reset register values
    for (int i = 0; i < 19; i++) begin
      p.pos_x = W_COORD'(dir_tab[i][0]);
      p.pos_y = W_COORD'(dir_tab[i][1]);
      p.heading = W_COORD'(dir_tab[i][2]);
      send_pose(p);
    end

    // Random poses over several register settings
    for (int k = 1; k <= 5; k++) begin
      drain_cmds();
      apply_setting(k);
      tx_idle = (k == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_idle = (k == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (k == 3) begin
        // stall the output for a long stretch while poses keep coming back to back
        tx_idle = 1'b0;
        rx_hold_cycles = 500;
        repeat (60) send_pose(rand_pose());
        tx_idle = 1'b1;
        rx_idle = 1'b1;
      end
      for (int n = 0; n < 64; n++) begin
        // pause the sender once until the pipeline has emptied
        if (k == 4 && n == 32) drain_cmds();
        send_pose(rand_pose());
      end
    end

    drain_cmds();
    repeat (40) @(posedge clk);
    $display("Covered %0d poses over six register settings, incl. a long output stall.",
             sb.poses_seen);
    $display("Commands seen: %0d stopped, %0d turning in place, %0d driving straight.",
             sb.n_stopped, sb.n_turning, sb.n_driving);
    if (sb.mismatch_count == 0 && sb.pending_cmds.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
